// ===== rtl/dqa_pkg.sv =====
// Shared types, constants and helpers for the DNS A-record responder.
// Used by dqa_front, dqa_queue, dqa_back and dns_query_to_a_answer.
`timescale 1ns / 1ps

package dqa_pkg;

  localparam int MAX_REPLY_BYTES = 512;
  localparam int TAIL_BYTES      = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] REPLY_LIMIT = 16'(MAX_REPLY_BYTES - TAIL_BYTES);

  localparam logic [2:0] VERDICT_SEND       = 3'd0;
  localparam logic [2:0] VERDICT_SHORT      = 3'd1;
  localparam logic [2:0] VERDICT_COMPRESSED = 3'd2;
  localparam logic [2:0] VERDICT_TRUNCATED  = 3'd3;
  localparam logic [2:0] VERDICT_TOO_LONG   = 3'd4;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_DROP,
    CMD_TAIL
  } cmd_kind_t;

  // One request from the parser to the emitter.
  typedef struct packed {
    cmd_kind_t   kind;
    logic        has_byte;
    logic [7:0]  data;
    logic [2:0]  verdict;
    logic [31:0] addr;
    logic [15:0] port;
  } cmd_t;

  // Answer record: pointer to offset 12, type A, class IN, TTL 60, RDLENGTH 4.
  function automatic logic [7:0] tail_byte(input logic [3:0] k, input logic [31:0] own);
    logic [7:0] v;
    case (k)
      4'd0:    v = 8'hC0;
      4'd1:    v = 8'h0C;
      4'd3:    v = 8'h01;
      4'd5:    v = 8'h01;
      4'd9:    v = 8'h3C;
      4'd11:   v = 8'h04;
      4'd12:   v = own[31:24];
      4'd13:   v = own[23:16];
      4'd14:   v = own[15:8];
      4'd15:   v = own[7:0];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/dqa_front.sv =====
// Parser front end: accepts query bytes, walks labels, issues emit requests.
// Depends on dqa_pkg.
`timescale 1ns / 1ps

module dqa_front import dqa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  payload_byte,
  input  logic        frame_end,
  input  logic [31:0] sender_address,
  input  logic [15:0] sender_port,
  output logic        push,
  output cmd_t        cmd
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_TAIL,
    PH_SKIP
  } phase_t;

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] nlp_r, nlp_nxt;
  logic [15:0] qend_r, qend_nxt;
  phase_t      phase_r, phase_nxt;
  logic [2:0]  drop_r, drop_nxt;

  logic [16:0] label_sum;
  logic [16:0] qend_sum;
  logic [16:0] pos_inc;
  logic [16:0] len;
  logic        in_q;
  logic        emit_ok;
  logic [7:0]  rewritten;
  logic [2:0]  verdict;

  function automatic logic [15:0] sat16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [7:0] rewrite(input logic [15:0] p, input logic [7:0] b);
    logic [7:0] v;
    case (p)
      16'd2:   v = 8'h81;
      16'd3:   v = 8'h80;
      16'd7:   v = 8'h01;
      16'd6, 16'd8, 16'd9, 16'd10, 16'd11: v = 8'h00;
      default: v = b;
    endcase
    return v;
  endfunction

  assign label_sum = {1'b0, pos_r} + {9'd0, payload_byte} + 17'd1;
  assign qend_sum  = {1'b0, pos_r} + 17'd5;
  assign pos_inc   = {1'b0, pos_r} + 17'd1;
  assign len       = pos_inc;

  // Advance the label walk for the current byte.
  always_comb begin
    nlp_nxt   = nlp_r;
    qend_nxt  = qend_r;
    phase_nxt = phase_r;
    drop_nxt  = drop_r;
    case (phase_r)
      PH_HEADER: begin
        if (pos_r >= 16'd11) phase_nxt = PH_NAME;
      end
      PH_NAME: begin
        if (pos_r == nlp_r) begin
          if (payload_byte == 8'd0) begin
            qend_nxt  = sat16(qend_sum);
            phase_nxt = PH_TAIL;
          end else if ((payload_byte & 8'hC0) != 8'd0) begin
            drop_nxt  = VERDICT_COMPRESSED;
            phase_nxt = PH_SKIP;
          end else begin
            nlp_nxt = sat16(label_sum);
          end
        end
      end
      PH_TAIL: begin
        if (pos_inc >= {1'b0, qend_r}) phase_nxt = PH_SKIP;
      end
      default: ;
    endcase
  end

  assign in_q      = (phase_r == PH_HEADER) || (phase_r == PH_NAME) || (pos_r < qend_r);
  assign emit_ok   = (drop_r == VERDICT_SEND) && in_q && (pos_r < REPLY_LIMIT);
  assign rewritten = rewrite(pos_r, payload_byte);

  always_comb begin
    if (len < 17'd12)
      verdict = VERDICT_SHORT;
    else if (drop_nxt != VERDICT_SEND)
      verdict = VERDICT_COMPRESSED;
    else if ((phase_nxt == PH_HEADER) || (phase_nxt == PH_NAME) || ({1'b0, qend_nxt} > len))
      verdict = VERDICT_TRUNCATED;
    else if (qend_nxt > REPLY_LIMIT)
      verdict = VERDICT_TOO_LONG;
    else
      verdict = VERDICT_SEND;
  end

  always_comb begin
    cmd.addr     = sender_address;
    cmd.port     = sender_port;
    cmd.data     = rewritten;
    cmd.has_byte = 1'b0;
    cmd.verdict  = VERDICT_SEND;
    cmd.kind     = CMD_BYTE;
    if (frame_end) begin
      if (verdict != VERDICT_SEND) begin
        cmd.kind    = CMD_DROP;
        cmd.verdict = verdict;
        cmd.data    = 8'h00;
      end else begin
        cmd.kind     = CMD_TAIL;
        cmd.has_byte = pos_r < qend_nxt;
      end
    end
  end

  assign push = accept && (frame_end || emit_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 16'd0;
      nlp_r   <= 16'd12;
      qend_r  <= 16'd0;
      phase_r <= PH_HEADER;
      drop_r  <= VERDICT_SEND;
    end else if (accept) begin
      if (frame_end) begin
        pos_r   <= 16'd0;
        nlp_r   <= 16'd12;
        qend_r  <= 16'd0;
        phase_r <= PH_HEADER;
        drop_r  <= VERDICT_SEND;
      end else begin
        pos_r   <= pos_nxt;
        nlp_r   <= nlp_nxt;
        qend_r  <= qend_nxt;
        phase_r <= phase_nxt;
        drop_r  <= drop_nxt;
      end
    end
  end

  assign pos_nxt = sat16(pos_inc);

endmodule

// ===== rtl/dqa_queue.sv =====
// Short request queue between parser and emitter.
// Depends on dqa_pkg for cmd_t and the queue depth.
`timescale 1ns / 1ps

module dqa_queue import dqa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign head  = mem[rd_ptr_r];
  assign empty = count_r == QCNT_W'(0);
  assign full  = count_r == QCNT_W'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== rtl/dqa_back.sv =====
// Emitter back end: turns queued requests into response bytes, appends answer.
// Depends on dqa_pkg.
`timescale 1ns / 1ps

module dqa_back import dqa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        head,
  input  logic        empty,
  input  logic [31:0] own_address,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_reply_byte,
  output logic        out_reply_end,
  output logic [2:0]  out_verdict,
  output logic [31:0] out_reply_address,
  output logic [15:0] out_reply_port
);

  logic        valid_r;
  logic [7:0]  byte_r, byte_nxt;
  logic        end_r, end_nxt;
  logic [2:0]  verdict_r, verdict_nxt;
  logic [31:0] addr_r;
  logic [15:0] port_r;
  logic [4:0]  step_r, step_nxt;
  logic [4:0]  eff_step;
  logic [3:0]  k;
  logic        advance;
  logic        load;
  logic        done;

  assign advance  = !valid_r || out_ready;
  assign load     = advance && !empty;
  assign eff_step = (step_r == 5'd0 && !head.has_byte) ? 5'd1 : step_r;
  assign k        = 4'(eff_step - 5'd1);

  always_comb begin
    byte_nxt    = head.data;
    end_nxt     = 1'b0;
    verdict_nxt = VERDICT_SEND;
    done        = 1'b1;
    step_nxt    = 5'd0;
    case (head.kind)
      CMD_BYTE: ;
      CMD_DROP: begin
        byte_nxt    = 8'h00;
        end_nxt     = 1'b1;
        verdict_nxt = head.verdict;
      end
      CMD_TAIL: begin
        if (eff_step != 5'd0) begin
          byte_nxt = tail_byte(k, own_address);
          end_nxt  = k == 4'd15;
        end
        done     = end_nxt;
        step_nxt = done ? 5'd0 : eff_step + 5'd1;
      end
      default: ;
    endcase
  end

  assign pop = load && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= 5'd0;
    end else if (advance) begin
      valid_r <= !empty;
      if (load) step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r    <= byte_nxt;
      end_r     <= end_nxt;
      verdict_r <= verdict_nxt;
      addr_r    <= head.addr;
      port_r    <= head.port;
    end
  end

  assign out_valid         = valid_r;
  assign out_reply_byte    = byte_r;
  assign out_reply_end     = end_r;
  assign out_verdict       = verdict_r;
  assign out_reply_address = addr_r;
  assign out_reply_port    = port_r;

endmodule

// ===== rtl/dns_query_to_a_answer.sv =====
// Top level of the DNS A-record responder: parser, request queue, emitter.
// Depends on dqa_pkg, dqa_front, dqa_queue and dqa_back.
//
//   channel  | ports                                       | handshake
//   ---------+---------------------------------------------+-------------------
//   in       | in_payload_byte, in_frame_end, in_sender_*  | in_valid/in_ready
//   out      | out_reply_byte/_end, out_verdict, out_reply_* | out_valid/out_ready
//   cfg      | cfg_wdata (own address)                     | cfg_we, no wait
//
// One query byte is taken per cycle while the request queue has room.
// Each passed byte is written into the request queue and leaves from there
// through the output register; the final byte of a good frame has the emitter
// append the answer record. The queue takes three more requests behind it,
// so a frame that follows at once sees in_ready low while the answer goes out.
// Reset (rst_n low at a clock edge) empties the queue and output, rewinds
// the parser to the header and clears the own address.
// A stall on the out side backs up through the queue to in_ready.
`timescale 1ns / 1ps

module dns_query_to_a_answer import dqa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_frame_end,
  input  logic [31:0] in_sender_address,
  input  logic [15:0] in_sender_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_reply_byte,
  output logic        out_reply_end,
  output logic [2:0]  out_verdict,
  output logic [31:0] out_reply_address,
  output logic [15:0] out_reply_port,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] own_addr_r;
  logic        accept;
  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  logic        q_full;
  cmd_t        push_cmd;
  cmd_t        head_cmd;

  // Hold own address; user must write it only while block is idle (unchecked).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= 32'd0;
    end else if (cfg_we) begin
      own_addr_r <= cfg_wdata;
    end
  end

  // Take a byte whenever the queue can hold its request.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  dqa_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .payload_byte   (in_payload_byte),
    .frame_end      (in_frame_end),
    .sender_address (in_sender_address),
    .sender_port    (in_sender_port),
    .push           (q_push),
    .cmd            (push_cmd)
  );

  dqa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  dqa_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head_cmd),
    .empty             (q_empty),
    .own_address       (own_addr_r),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reply_byte    (out_reply_byte),
    .out_reply_end     (out_reply_end),
    .out_verdict       (out_verdict),
    .out_reply_address (out_reply_address),
    .out_reply_port    (out_reply_port)
  );

  // Never push a request into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("request pushed into full queue");

  // Never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("request popped from empty queue");

  // A nonzero verdict rides only on the final result of a frame.
  a_verdict_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reply_end) |-> (out_verdict == VERDICT_SEND))
    else $error("verdict set on a non-final result");

  // A drop result carries a zero byte.
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict != VERDICT_SEND) |-> (out_reply_byte == 8'h00))
    else $error("drop result with nonzero byte");

endmodule

// ===== verif/dqa_reply_checker.sv =====
// Reply checker for dns_query_to_a_answer: predicts the reply stream from
// accepted requests and compares it against the out channel.
// Depends on dqa_pkg for the verdict codes and the reply byte limit.
`timescale 1ns / 1ps

module dqa_reply_checker import dqa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_frame_end,
  input  logic [31:0] in_sender_address,
  input  logic [15:0] in_sender_port,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_reply_byte,
  input  logic        out_reply_end,
  input  logic [2:0]  out_verdict,
  input  logic [31:0] out_reply_address,
  input  logic [15:0] out_reply_port,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          mismatch_count,
  output int          pending_replies
);

  localparam int unsigned HEADER_BYTES       = 12;
  localparam int unsigned QTYPE_QCLASS_BYTES = 4;
  localparam int unsigned POS_MAX            = 65535;
  localparam int          REPORT_LIMIT       = 10;
  localparam logic [15:0] NAME_POINTER       = 16'hC00C;
  localparam logic [15:0] TYPE_A             = 16'h0001;
  localparam logic [15:0] CLASS_IN           = 16'h0001;
  localparam logic [31:0] TTL_SECONDS        = 32'd60;
  localparam logic [15:0] RDATA_LENGTH       = 16'd4;
  localparam int          ANSWER_BYTES       = 16;

  typedef enum logic [1:0] {
    WALK_HEADER,
    WALK_NAME,
    WALK_QTAIL,
    WALK_SKIP
  } walk_phase_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [2:0]  verdict;
    logic [31:0] addr;
    logic [15:0] port;
  } reply_t;

  reply_t      expected_replies[$];
  logic [31:0] own_address;
  int unsigned byte_pos;
  int unsigned label_pos;
  int unsigned question_end;
  walk_phase_t walk;
  logic [2:0]  drop_code;
  int          errors;

  function automatic int unsigned clamp_pos(input int unsigned v);
    return (v > POS_MAX) ? POS_MAX : v;
  endfunction

  // Response flags, one answer, no authority or additional records.
  function automatic logic [7:0] rewrite_header(input int unsigned p, input logic [7:0] b);
    case (p)
      2:                return 8'h81;
      3:                return 8'h80;
      7:                return 8'h01;
      6, 8, 9, 10, 11:  return 8'h00;
      default:          return b;
    endcase
  endfunction

  task automatic clear_frame();
    byte_pos     = 0;
    label_pos    = HEADER_BYTES;
    question_end = 0;
    walk         = WALK_HEADER;
    drop_code    = VERDICT_SEND;
  endtask

  task automatic walk_name(input int unsigned p, input logic [7:0] b);
    case (walk)
      WALK_HEADER: if (p >= HEADER_BYTES - 1) walk = WALK_NAME;
      WALK_NAME: begin
        if (p == label_pos) begin
          if (b == 8'h00) begin
            question_end = clamp_pos(p + 1 + QTYPE_QCLASS_BYTES);
            walk = WALK_QTAIL;
          end else if (b[7:6] != 2'b00) begin
            drop_code = VERDICT_COMPRESSED;
            walk = WALK_SKIP;
          end else begin
            label_pos = clamp_pos(p + b + 1);
          end
        end
      end
      WALK_QTAIL: if (p + 1 >= question_end) walk = WALK_SKIP;
      default: ;
    endcase
  endtask

  task automatic predict_replies(input logic [7:0] b, input logic fin,
                                 input logic [31:0] a, input logic [15:0] port);
    int unsigned  p;
    int unsigned  len;
    logic [2:0]   v;
    logic [127:0] answer;
    p = byte_pos;
    if (!fin) begin
      if (drop_code == VERDICT_SEND && p < REPLY_LIMIT &&
          (walk == WALK_HEADER || walk == WALK_NAME || p < question_end))
        expected_replies.push_back({rewrite_header(p, b), 1'b0, VERDICT_SEND, a, port});
      walk_name(p, b);
      byte_pos = clamp_pos(p + 1);
    end else begin
      walk_name(p, b);
      len = p + 1;
      if (len < HEADER_BYTES) v = VERDICT_SHORT;
      else if (drop_code != VERDICT_SEND) v = VERDICT_COMPRESSED;
      else if (walk == WALK_HEADER || walk == WALK_NAME || question_end > len)
        v = VERDICT_TRUNCATED;
      else if (question_end > REPLY_LIMIT) v = VERDICT_TOO_LONG;
      else v = VERDICT_SEND;

      if (v != VERDICT_SEND) begin
        expected_replies.push_back({8'h00, 1'b1, v, a, port});
      end else begin
        if (p < question_end)
          expected_replies.push_back({rewrite_header(p, b), 1'b0, VERDICT_SEND, a, port});
        answer = {NAME_POINTER, TYPE_A, CLASS_IN, TTL_SECONDS, RDATA_LENGTH, own_address};
        for (int k = 0; k < ANSWER_BYTES; k++)
          expected_replies.push_back({answer[127 - 8 * k -: 8], k == ANSWER_BYTES - 1,
                                      VERDICT_SEND, a, port});
      end
      clear_frame();
    end
  endtask

  task automatic note_mismatch(input string tag, input reply_t want, input reply_t got);
    if (errors < REPORT_LIMIT) begin
      $write("%0t %s: expected byte %02h end %0d verdict %0d addr %08h port %04h, ",
             $time, tag, want.data, want.last, want.verdict, want.addr, want.port);
      $display("got byte %02h end %0d verdict %0d addr %08h port %04h",
               got.data, got.last, got.verdict, got.addr, got.port);
    end
    errors++;
  endtask

  always @(posedge clk) begin : scoreboard
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      own_address = '0;
      clear_frame();
      expected_replies.delete();
    end else begin
      if (cfg_we) own_address = cfg_wdata;
      if (in_valid && in_ready)
        predict_replies(in_payload_byte, in_frame_end, in_sender_address, in_sender_port);
      if (out_valid && out_ready) begin
        got = {out_reply_byte, out_reply_end, out_verdict, out_reply_address, out_reply_port};
        if (expected_replies.size() == 0) begin
          note_mismatch("reply with none waiting", '0, got);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) note_mismatch("reply mismatch", want, got);
        end
      end
    end
    pending_replies <= expected_replies.size();
    mismatch_count  <= errors;
  end

endmodule

// ===== verif/tb.sv =====
// Top of the dns_query_to_a_answer testbench: clock, reset, query stimulus,
// reply sink and the final verdict. Depends on dqa_pkg, the responder RTL and
// dqa_reply_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb;
  import dqa_pkg::*;

  localparam int          SETTLE_CYCLES   = 48;
  localparam int          RANDOM_PHASES   = 5;
  localparam int          RANDOM_REQUESTS = 470;
  localparam int          HEADER_BYTES    = 12;
  localparam int          MAX_LABEL       = 63;
  // Header, terminator and the four type/class bytes around the label bytes.
  localparam int          QUESTION_FRAME  = HEADER_BYTES + 1 + 4;
  localparam int          TIMEOUT_NS      = 8_000_000;
  localparam logic [7:0]  NAME_END        = 8'h00;
  localparam logic [7:0]  POINTER_LABEL   = 8'hC0;
  localparam logic [7:0]  RESERVED_LABEL  = 8'h40;
  localparam logic [7:0]  EXTENDED_LABEL  = 8'h80;

  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } header_fill_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_payload_byte = '0;
  logic        in_frame_end = 1'b0;
  logic [31:0] in_sender_address = '0;
  logic [15:0] in_sender_port = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_reply_byte;
  logic        out_reply_end;
  logic [2:0]  out_verdict;
  logic [31:0] out_reply_address;
  logic [15:0] out_reply_port;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  int          mismatch_count;
  int          pending_replies;
  logic [7:0]  query_bytes[$];   // payload of the query being assembled
  bit          source_idle_on = 1'b1;
  bit          sink_stall_on = 1'b1;
  int          ready_hold;
  int          requests_sent;

  always #5 clk = ~clk;

  dns_query_to_a_answer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_payload_byte   (in_payload_byte),
    .in_frame_end      (in_frame_end),
    .in_sender_address (in_sender_address),
    .in_sender_port    (in_sender_port),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reply_byte    (out_reply_byte),
    .out_reply_end     (out_reply_end),
    .out_verdict       (out_verdict),
    .out_reply_address (out_reply_address),
    .out_reply_port    (out_reply_port),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  dqa_reply_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_payload_byte   (in_payload_byte),
    .in_frame_end      (in_frame_end),
    .in_sender_address (in_sender_address),
    .in_sender_port    (in_sender_port),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reply_byte    (out_reply_byte),
    .out_reply_end     (out_reply_end),
    .out_verdict       (out_verdict),
    .out_reply_address (out_reply_address),
    .out_reply_port    (out_reply_port),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .mismatch_count    (mismatch_count),
    .pending_replies   (pending_replies)
  );

  // Reply sink: hold out_ready for a random run, mostly short, now and then
  // a long stall that backs the queue up into in_ready.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!sink_stall_on) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 19) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(8, 40);
    end else begin
      out_ready  <= ($urandom_range(0, 2) != 0);
      ready_hold <= $urandom_range(0, 3);
    end
  end

  // Idle cycles before the next request: mostly none or a few, rarely long.
  function automatic int pick_gap();
    int r;
    if (!source_idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Present one request and hold it until accepted. Valid stays high into the
  // next request unless a gap is drawn, so back-to-back requests never see a
  // low/high pair of assignments in one step.
  task automatic push_request(input logic [7:0] data, input logic last,
                              input logic [31:0] addr, input logic [15:0] port);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_payload_byte   <= data;
    in_frame_end      <= last;
    in_sender_address <= addr;
    in_sender_port    <= port;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stream the assembled query; the sender fields stay fixed for the frame.
  task automatic send_query(input logic [31:0] addr, input logic [15:0] port);
    int n;
    n = query_bytes.size();
    for (int k = 0; k < n; k++) push_request(query_bytes[k], k == n - 1, addr, port);
    requests_sent += n;
    query_bytes.delete();
  endtask

  task automatic add_header(input header_fill_t fill);
    repeat (HEADER_BYTES) begin
      case (fill)
        FILL_ZERO: query_bytes.push_back(8'h00);
        FILL_ONES: query_bytes.push_back(8'hFF);
        default:   query_bytes.push_back(8'($urandom));
      endcase
    end
  endtask

  task automatic add_random(input int n);
    repeat (n) query_bytes.push_back(8'($urandom));
  endtask

  // Append labels whose length bytes and content add up to exactly total.
  // Never leave a single byte over, since a label needs at least two.
  task automatic add_labels(input int total, input int longest);
    int r;
    int len;
    r = total;
    while (r > 0) begin
      len = $urandom_range(1, (r - 1 < longest) ? r - 1 : longest);
      if (r - len - 1 == 1) len = (len > 1) ? len - 1 : len + 1;
      query_bytes.push_back(8'(len));
      add_random(len);
      r -= len + 1;
    end
  endtask

  // Drop valid, wait for every predicted reply to arrive, then let the
  // emitter finish any frame that produced nothing more to expect.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_own_address(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int phase_end;
    int kind;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_own_address(32'hFFFF_FFFF);

    // Smallest good query: root name, then type and class.
    add_header(FILL_RANDOM);
    query_bytes.push_back(NAME_END);
    add_random(4);
    send_query($urandom, 16'($urandom_range(0, 65535)));

    // All-ones header and sender, labels up to max length, bytes after question.
    add_header(FILL_ONES);
    add_labels(MAX_LABEL + 1, MAX_LABEL);
    query_bytes.push_back(NAME_END);
    repeat (7) query_bytes.push_back(8'hFF);
    send_query(32'hFFFF_FFFF, 16'hFFFF);

    // All-zero header and sender.
    add_header(FILL_ZERO);
    add_labels(10, 4);
    query_bytes.push_back(NAME_END);
    repeat (4) query_bytes.push_back(8'h00);
    send_query(32'h0, 16'h0);

    // Short frames: one byte, and one byte less than a header.
    add_random(1);
    send_query($urandom, 16'($urandom_range(0, 65535)));
    add_random(HEADER_BYTES - 1);
    send_query($urandom, 16'($urandom_range(0, 65535)));

    // Header only: the name never starts.
    add_header(FILL_RANDOM);
    send_query($urandom, 16'($urandom_range(0, 65535)));

    // Compression pointer as the first label.
    add_header(FILL_RANDOM);
    query_bytes.push_back(POINTER_LABEL);
    query_bytes.push_back(8'h0C);
    add_random(4);
    send_query($urandom, 16'($urandom_range(0, 65535)));

    // Reserved label types, one after a normal label, one straight away.
    add_header(FILL_RANDOM);
    add_labels(5, 4);
    query_bytes.push_back(RESERVED_LABEL);
    add_random(6);
    send_query($urandom, 16'($urandom_range(0, 65535)));
    add_header(FILL_RANDOM);
    query_bytes.push_back(EXTENDED_LABEL);
    add_random(3);
    send_query($urandom, 16'($urandom_range(0, 65535)));

    // Name never terminated; then a label that runs past the frame end.
    add_header(FILL_RANDOM);
    add_labels(20, 6);
    send_query($urandom, 16'($urandom_range(0, 65535)));
    add_header(FILL_RANDOM);
    query_bytes.push_back(8'd30);
    add_random(5);
    send_query($urandom, 16'($urandom_range(0, 65535)));

    // Terminated name, but type and class cut short.
    add_header(FILL_RANDOM);
    add_labels(8, 7);
    query_bytes.push_back(NAME_END);
    add_random(2);
    send_query($urandom, 16'($urandom_range(0, 65535)));

    // Good query with trailing records that must be swallowed.
    add_header(FILL_RANDOM);
    add_labels(30, 12);
    query_bytes.push_back(NAME_END);
    add_random(13);
    send_query($urandom, 16'($urandom_range(0, 65535)));

    wait_until_idle();
    write_own_address(32'h0);

    // Question ending right at the reply limit, then one byte beyond it.
    add_header(FILL_RANDOM);
    add_labels(int'(REPLY_LIMIT) - QUESTION_FRAME, MAX_LABEL);
    query_bytes.push_back(NAME_END);
    add_random(4);
    send_query($urandom, 16'($urandom_range(0, 65535)));
    add_header(FILL_RANDOM);
    add_labels(int'(REPLY_LIMIT) - QUESTION_FRAME + 1, MAX_LABEL);
    query_bytes.push_back(NAME_END);
    add_random(4);
    send_query($urandom, 16'($urandom_range(0, 65535)));

    // Short question in a long frame, and a pointer found past the limit.
    add_header(FILL_RANDOM);
    add_labels(40, MAX_LABEL);
    query_bytes.push_back(NAME_END);
    add_random(300);
    send_query($urandom, 16'($urandom_range(0, 65535)));
    add_header(FILL_RANDOM);
    add_labels(520, MAX_LABEL);
    query_bytes.push_back(POINTER_LABEL);
    add_random(3);
    send_query($urandom, 16'($urandom_range(0, 65535)));

    // Frame past the 16-bit position range: labels walk up to the last
    // position, after which every byte is read as a label at that position.
    wait_until_idle();
    source_idle_on <= 1'b0;
    sink_stall_on  <= 1'b0;
    write_own_address($urandom);
    add_header(FILL_RANDOM);
    add_labels(65535 - HEADER_BYTES, MAX_LABEL);
    query_bytes.push_back(8'd5);
    query_bytes.push_back(8'd5);
    query_bytes.push_back(NAME_END);
    add_random(6);
    send_query($urandom, 16'($urandom_range(0, 65535)));

    // Random phases, each with its own address and idle mix; the first has
    // no idling at all. Each phase starts with the sender paused until every
    // reply is in.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_until_idle();
      source_idle_on <= ph[0] || ph == RANDOM_PHASES - 1;
      sink_stall_on  <= ph[1] || ph == RANDOM_PHASES - 1;
      write_own_address($urandom);
      phase_end = requests_sent + RANDOM_REQUESTS / RANDOM_PHASES;
      while (requests_sent < phase_end) begin
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
          add_random($urandom_range(1, HEADER_BYTES - 1));
        end else begin
          add_header(FILL_RANDOM);
          if (kind < 66) begin
            // Well-formed query, sometimes with trailing records.
            add_labels($urandom_range(0, 1) ? $urandom_range(2, 40) : 0, 12);
            query_bytes.push_back(NAME_END);
            add_random(4);
            if ($urandom_range(0, 1)) add_random($urandom_range(1, 6));
          end else if (kind < 76) begin
            add_labels($urandom_range(0, 1) ? $urandom_range(2, 20) : 0, 8);
            query_bytes.push_back({2'($urandom_range(1, 3)), 6'($urandom)});
            add_random($urandom_range(0, 6));
          end else if (kind < 84) begin
            add_labels($urandom_range(0, 1) ? $urandom_range(2, 20) : 0, 8);
            if ($urandom_range(0, 1)) begin
              query_bytes.push_back(8'($urandom_range(4, MAX_LABEL)));
              add_random($urandom_range(0, 3));
            end
          end else if (kind < 92) begin
            add_labels($urandom_range(2, 20), 8);
            query_bytes.push_back(NAME_END);
            add_random($urandom_range(0, 3));
          end else begin
            add_random($urandom_range(0, 30));
          end
        end
        send_query($urandom, 16'($urandom_range(0, 65535)));
      end
    end

    wait_until_idle();
    if (mismatch_count == 0 && pending_replies == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
